// ----- src/wstd_pkg.sv -----
// ----------------------------------------------------------------------------
// wstd_pkg: shared definitions for the work-stealing task dispatcher
// Opcodes and result status codes used by the channels and the dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wstd_pkg;

  localparam logic OP_SUBMIT  = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [1:0] ST_SUBMITTED = 2'd0;
  localparam logic [1:0] ST_GRANTED   = 2'd1;
  localparam logic [1:0] ST_NONE      = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef logic [1:0] status_t;

endpackage

`default_nettype wire

// ----- src/wstd_if.sv -----
// ----------------------------------------------------------------------------
// wstd_if: request and result channels of the task dispatcher
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface wstd_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] task_handle;
  logic [1:0]  worker_index;

  modport source (output valid, output opcode, output task_handle, output worker_index,
                  input ready);
  modport sink   (input valid, input opcode, input task_handle, input worker_index,
                  output ready);
endinterface

interface wstd_rsp_if;
  logic              valid;
  logic              ready;
  wstd_pkg::status_t status;
  logic [31:0]       granted_task;
  logic [1:0]        queue_used;

  modport source (output valid, output status, output granted_task, output queue_used,
                  input ready);
  modport sink   (input valid, input status, input granted_task, input queue_used,
                  output ready);
endinterface

`default_nettype wire

// ----- src/work_stealing_task_dispatcher.sv -----
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher: per-worker task queues with stealing
// Submits go round-robin into per-worker FIFOs held in one memory; a worker
// request pops its own queue or steals from the lowest-numbered busy queue.
// ----------------------------------------------------------------------------
//  channel   direction  fields                                  handshake
//  in_req    sink       opcode, task_handle, worker_index       valid/ready
//  out_rsp   source     status, granted_task, queue_used        valid/ready
//
// A request is accepted only in the idle step and then runs through queue
// select, pointer step with memory access, count step and result before the
// next is accepted. The result is registered when the result step is left.
// The pointer and count steps share one incrementer.
// Reset clears all pointers, counts and the round-robin pointer.
// A result waiting on out_rsp holds the block in its result step until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module work_stealing_task_dispatcher #(
  parameter int WORKERS     = 4,
  parameter int QUEUE_DEPTH = 16,
  parameter int TASK_WIDTH  = 32
) (
  input  wire        clk,
  input  wire        rst_n,
  wstd_req_if.sink   in_req,
  wstd_rsp_if.source out_rsp
);

  localparam int QW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRIES = WORKERS * QUEUE_DEPTH;
  localparam int AW = $clog2(ENTRIES);
  localparam int SW = (TASK_WIDTH < 32) ? TASK_WIDTH : 32;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEL  = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_CNT  = 3'd3;
  localparam logic [2:0] S_RES  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic              op_r;
  logic [SW-1:0]     handle_r;
  logic [1:0]        worker_r;
  logic [QW-1:0]     q_r, q_nxt;
  logic              found_r, found_nxt;
  logic              update_r;
  wstd_pkg::status_t status_r;
  logic [QW-1:0]     rr_r;

  logic [PW-1:0]      head_r [WORKERS];
  logic [PW-1:0]      tail_r [WORKERS];
  logic [CW-1:0]      cnt_r  [WORKERS];
  logic [WORKERS-1:0] busy_r;

  logic [SW-1:0] mem [ENTRIES];
  logic [SW-1:0] rd_data_r;

  logic              out_valid_r;
  wstd_pkg::status_t out_status_r;
  logic [31:0]       out_task_r;
  logic [1:0]        out_queue_r;

  // Shared incrementer: steps a pointer with wrap, or a count up or down.
  logic [CW-1:0] unit_a;
  logic          unit_up;
  logic          unit_wrap;
  logic [CW-1:0] unit_sum;
  logic [CW-1:0] unit_y;

  logic [QW-1:0] own_q;
  logic          own_ok;
  logic [QW-1:0] low_q;
  logic          low_any;
  logic          full;
  logic [AW-1:0] mem_addr;
  logic [PW-1:0] ptr_sel;

  assign unit_sum = unit_up ? unit_a + CW'(1) : unit_a - CW'(1);
  assign unit_y   = (unit_wrap && unit_sum == CW'(QUEUE_DEPTH)) ? '0 : unit_sum;

  assign own_q  = QW'(worker_r);
  assign own_ok = ({30'd0, worker_r} < 32'(WORKERS)) && busy_r[own_q];

  always_comb begin
    low_q   = '0;
    low_any = 1'b0;
    for (int i = WORKERS - 1; i >= 0; i--) begin
      if (busy_r[i]) begin
        low_q   = QW'(i);
        low_any = 1'b1;
      end
    end
  end

  assign full     = (cnt_r[q_r] == CW'(QUEUE_DEPTH));
  assign ptr_sel  = (op_r == wstd_pkg::OP_SUBMIT) ? tail_r[q_r] : head_r[q_r];
  assign mem_addr = AW'(q_r * QUEUE_DEPTH) + AW'(ptr_sel);

  always_comb begin
    unit_a    = '0;
    unit_up   = 1'b1;
    unit_wrap = 1'b0;
    case (state_r)
      S_EXEC: begin
        unit_a    = CW'(ptr_sel);
        unit_up   = 1'b1;
        unit_wrap = 1'b1;
      end
      S_CNT: begin
        unit_a    = cnt_r[q_r];
        unit_up   = (op_r == wstd_pkg::OP_SUBMIT);
        unit_wrap = 1'b0;
      end
      default: begin
        unit_a = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    found_nxt = found_r;
    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          state_nxt = S_SEL;
        end
      end
      S_SEL: begin
        if (op_r == wstd_pkg::OP_SUBMIT) begin
          q_nxt     = rr_r;
          found_nxt = 1'b1;
        end else if (own_ok) begin
          q_nxt     = own_q;
          found_nxt = 1'b1;
        end else begin
          q_nxt     = low_q;
          found_nxt = low_any;
        end
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_CNT;
      end
      S_CNT: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_req.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rr_r    <= '0;
      busy_r  <= '0;
      for (int i = 0; i < WORKERS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      q_r      <= '0;
      found_r  <= 1'b0;
      update_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      q_r     <= q_nxt;
      found_r <= found_nxt;
      if (state_r == S_EXEC) begin
        update_r <= 1'b0;
        if (op_r == wstd_pkg::OP_SUBMIT) begin
          if (!full) begin
            tail_r[q_r] <= PW'(unit_y);
            update_r    <= 1'b1;
          end
        end else if (found_r) begin
          head_r[q_r] <= PW'(unit_y);
          update_r    <= 1'b1;
        end
      end
      if (state_r == S_CNT) begin
        if (update_r) begin
          cnt_r[q_r]  <= unit_y;
          busy_r[q_r] <= (unit_y != '0);
        end
        if (op_r == wstd_pkg::OP_SUBMIT) begin
          rr_r <= (rr_r == QW'(WORKERS - 1)) ? '0 : rr_r + QW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      op_r     <= in_req.opcode;
      handle_r <= SW'(in_req.task_handle);
      worker_r <= in_req.worker_index;
    end
    if (state_r == S_EXEC) begin
      if (op_r == wstd_pkg::OP_SUBMIT) begin
        status_r <= full ? wstd_pkg::ST_FULL : wstd_pkg::ST_SUBMITTED;
      end else begin
        status_r <= found_r ? wstd_pkg::ST_GRANTED : wstd_pkg::ST_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && op_r == wstd_pkg::OP_SUBMIT && !full) begin
      mem[mem_addr] <= handle_r;
    end
    if (state_r == S_EXEC && op_r == wstd_pkg::OP_REQUEST && found_r) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_RES && (!out_valid_r || out_rsp.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RES && (!out_valid_r || out_rsp.ready)) begin
      out_status_r <= status_r;
      out_task_r   <= (status_r == wstd_pkg::ST_GRANTED) ? 32'(rd_data_r) : 32'd0;
      out_queue_r  <= (status_r == wstd_pkg::ST_NONE) ? 2'd0 : 2'(q_r);
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.granted_task = out_task_r;
  assign out_rsp.queue_used   = out_queue_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[q_r] <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_busy_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> busy_r[q_r] == (cnt_r[q_r] != '0))
    else $error("busy flag disagrees with queue count");

  a_grant_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == wstd_pkg::OP_REQUEST && found_r) |-> busy_r[q_r])
    else $error("grant selected an empty queue");

  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> state_r == S_SEL)
    else $error("accepted request did not start the sequence");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == wstd_pkg::ST_NONE) |->
      (out_task_r == 32'd0 && out_queue_r == 2'd0))
    else $error("empty result carries a task or queue");

endmodule

`default_nettype wire

// ----- test/wstd_dispatch_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wstd_dispatch_checker: scoreboard for the work-stealing task dispatcher
// Watches both channels, keeps its own copy of the per-worker queues and the
// round-robin pointer, predicts the result of every accepted request and
// compares each delivered result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module wstd_dispatch_checker (
  input  wire  clk,
  input  wire  rst_n,
  wstd_req_if  req_ch,
  wstd_rsp_if  rsp_ch,
  output int   fail_count,
  output int   open_count,
  output int   grant_count,
  output int   drop_count,
  output int   empty_count
);

  localparam int NUM_Q = 4;
  localparam int DEPTH = 16;

  typedef struct packed {
    wstd_pkg::status_t status;
    logic [31:0]       granted;
    logic [1:0]        queue_id;
  } dispatch_result_t;

  logic [31:0]      task_slots [NUM_Q][DEPTH];
  logic [3:0]       rd_ptr     [NUM_Q];
  logic [3:0]       wr_ptr     [NUM_Q];
  logic [4:0]       depth_used [NUM_Q];
  logic [1:0]       rr_ptr;
  dispatch_result_t owed_results[$];

  function automatic dispatch_result_t dispatch_outcome(logic op, logic [31:0] handle,
                                                        logic [1:0] worker);
    dispatch_result_t r;
    int src;
    r = '0;
    src = -1;
    if (op == wstd_pkg::OP_SUBMIT) begin
      r.queue_id = rr_ptr;
      if (depth_used[rr_ptr] == DEPTH) begin
        r.status = wstd_pkg::ST_FULL;
      end else begin
        task_slots[rr_ptr][wr_ptr[rr_ptr]] = handle;
        wr_ptr[rr_ptr] = wr_ptr[rr_ptr] + 1'b1;
        depth_used[rr_ptr] = depth_used[rr_ptr] + 1'b1;
        r.status = wstd_pkg::ST_SUBMITTED;
      end
      rr_ptr = rr_ptr + 1'b1;
    end else begin
      // A worker serves its own queue first, otherwise steals from the
      // lowest-numbered queue that holds anything.
      if (depth_used[worker] != 0) begin
        src = int'(worker);
      end else begin
        for (int i = 0; i < NUM_Q; i++) begin
          if (src < 0 && depth_used[i] != 0) src = i;
        end
      end
      if (src < 0) begin
        r.status = wstd_pkg::ST_NONE;
      end else begin
        r.status = wstd_pkg::ST_GRANTED;
        r.granted = task_slots[src][rd_ptr[src]];
        r.queue_id = src[1:0];
        rd_ptr[src] = rd_ptr[src] + 1'b1;
        depth_used[src] = depth_used[src] - 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    dispatch_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_Q; i++) begin
        rd_ptr[i] = '0;
        wr_ptr[i] = '0;
        depth_used[i] = '0;
      end
      rr_ptr = '0;
      owed_results.delete();
      fail_count = 0;
      grant_count = 0;
      drop_count = 0;
      empty_count = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          if (fail_count < 40) begin
            $display("%0t: result with nothing expected: status %0d task %h queue %0d",
                     $time, rsp_ch.status, rsp_ch.granted_task, rsp_ch.queue_used);
          end
        end else begin
          want = owed_results.pop_front();
          case (want.status)
            wstd_pkg::ST_GRANTED: grant_count++;
            wstd_pkg::ST_FULL:    drop_count++;
            wstd_pkg::ST_NONE:    empty_count++;
            default:              ;
          endcase
          if (rsp_ch.status !== want.status) begin
            fail_count++;
            if (fail_count < 40) begin
              $display("%0t: status expected %0d actual %0d",
                       $time, want.status, rsp_ch.status);
            end
          end
          if (rsp_ch.granted_task !== want.granted) begin
            fail_count++;
            if (fail_count < 40) begin
              $display("%0t: granted_task expected %h actual %h",
                       $time, want.granted, rsp_ch.granted_task);
            end
          end
          if (rsp_ch.queue_used !== want.queue_id) begin
            fail_count++;
            if (fail_count < 40) begin
              $display("%0t: queue_used expected %0d actual %0d",
                       $time, want.queue_id, rsp_ch.queue_used);
            end
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        owed_results.push_back(dispatch_outcome(req_ch.opcode, req_ch.task_handle,
                                                req_ch.worker_index));
      end
    end
    open_count = owed_results.size();
  end

endmodule

// ----- test/work_stealing_task_dispatcher_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_task_dispatcher_test: regression for the task dispatcher
// Drives a directed sequence of submits and worker requests, then phases of
// random traffic biased toward filling or draining the queues, with random
// stalls on both channels. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module work_stealing_task_dispatcher_test;

  logic clk;
  logic rst_n;
  int   idle_level;
  int   sent_count;
  int   fail_count;
  int   open_count;
  int   grant_count;
  int   drop_count;
  int   empty_count;

  wstd_req_if req_ch ();
  wstd_rsp_if rsp_ch ();

  work_stealing_task_dispatcher u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  wstd_dispatch_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_ch      (req_ch),
    .rsp_ch      (rsp_ch),
    .fail_count  (fail_count),
    .open_count  (open_count),
    .grant_count (grant_count),
    .drop_count  (drop_count),
    .empty_count (empty_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic send_item(input logic op, input logic [31:0] handle,
                           input logic [1:0] worker);
    int gap;
    @(negedge clk);
    if (idle_level != 0 && $urandom_range(0, 15) < idle_level * 3) begin
      gap = $urandom_range(1, 18);
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.opcode = op;
    req_ch.task_handle = handle;
    req_ch.worker_index = worker;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic random_item(input int submit_pct);
    logic [31:0] handle;
    logic [1:0]  worker;
    case ($urandom_range(0, 9))
      0:       handle = '0;
      1:       handle = '1;
      default: handle = $urandom;
    endcase
    worker = 2'($urandom_range(0, 3));
    if ($urandom_range(1, 100) <= submit_pct) begin
      send_item(wstd_pkg::OP_SUBMIT, handle, worker);
    end else begin
      send_item(wstd_pkg::OP_REQUEST, handle, worker);
    end
  endtask

  initial begin
    int stall;
    rsp_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_level != 0 && $urandom_range(0, 15) < idle_level * 3) begin
        rsp_ch.ready = 1'b0;
        stall = $urandom_range(1, 18);
        repeat (stall - 1) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  initial begin
    int submit_bias [14];
    submit_bias = '{90, 10, 95, 50, 5, 80, 20, 95, 40, 60, 10, 90, 30, 50};
    rst_n = 1'b0;
    idle_level = 0;
    sent_count = 0;
    req_ch.valid = 1'b0;
    req_ch.opcode = wstd_pkg::OP_SUBMIT;
    req_ch.task_handle = '0;
    req_ch.worker_index = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Every queue empty: each worker gets nothing.
    idle_level = 1;
    send_item(wstd_pkg::OP_REQUEST, 32'h0000_0000, 2'd0);
    send_item(wstd_pkg::OP_REQUEST, 32'hFFFF_FFFF, 2'd1);
    send_item(wstd_pkg::OP_REQUEST, 32'h0000_0000, 2'd2);
    send_item(wstd_pkg::OP_REQUEST, 32'hFFFF_FFFF, 2'd3);
    // Round-robin submits with extreme handles, wrapping back to queue 0.
    send_item(wstd_pkg::OP_SUBMIT, 32'h0000_0000, 2'd3);
    send_item(wstd_pkg::OP_SUBMIT, 32'hFFFF_FFFF, 2'd0);
    send_item(wstd_pkg::OP_SUBMIT, 32'h5555_5555, 2'd1);
    send_item(wstd_pkg::OP_SUBMIT, 32'hAAAA_AAAA, 2'd2);
    send_item(wstd_pkg::OP_SUBMIT, 32'h1234_5678, 2'd3);
    // Own queue first, then stealing from the lowest busy queue.
    send_item(wstd_pkg::OP_REQUEST, 32'h0000_0000, 2'd1);
    send_item(wstd_pkg::OP_REQUEST, 32'h0000_0000, 2'd1);
    send_item(wstd_pkg::OP_REQUEST, 32'h0000_0000, 2'd1);
    send_item(wstd_pkg::OP_REQUEST, 32'h0000_0000, 2'd3);
    send_item(wstd_pkg::OP_REQUEST, 32'h0000_0000, 2'd0);
    send_item(wstd_pkg::OP_REQUEST, 32'hFFFF_FFFF, 2'd2);

    // Phases vary the submit bias between filling the queues toward overflow
    // and draining them toward empty; the last phases run without stalls.
    for (int p = 0; p < 14; p++) begin
      idle_level = (p >= 12) ? 0 : $urandom_range(0, 2);
      repeat (100) random_item(submit_bias[p]);
    end
    @(negedge clk);
    req_ch.valid = 1'b0;

    while (open_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d requests; %0d tasks granted, %0d submits dropped on full queues,",
             sent_count, grant_count, drop_count);
    $display("%0d requests found every queue empty; %0d mismatches.",
             empty_count, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", open_count);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/wstd_pkg.sv
src/wstd_if.sv
src/work_stealing_task_dispatcher.sv
test/wstd_dispatch_checker.sv
test/work_stealing_task_dispatcher_test.sv
